@@ rtl/core/cts_pkg.sv @@
// Shared types, constants and character helpers for the C token scanner.
package cts_pkg;

    localparam int KwChars  = 8;
    localparam int KwIdxW   = $clog2(KwChars);
    localparam int LenBits  = 16;
    localparam int KwCount  = 32;
    localparam int QDepth   = 4;
    localparam int QPtrW    = $clog2(QDepth);

    localparam logic [7:0] ChSlash   = 8'h2F;
    localparam logic [7:0] ChStar    = 8'h2A;
    localparam logic [7:0] ChHash    = 8'h23;
    localparam logic [7:0] ChUnder   = 8'h5F;
    localparam logic [7:0] ChDot     = 8'h2E;
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChDquote  = 8'h22;
    localparam logic [7:0] ChSquote  = 8'h27;

    localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

    typedef enum logic [7:0] {
        MODE_IDLE      = 8'b0000_0001,
        MODE_SLASH     = 8'b0000_0010,
        MODE_LINE      = 8'b0000_0100,
        MODE_BLOCK     = 8'b0000_1000,
        MODE_DIRECTIVE = 8'b0001_0000,
        MODE_WORD      = 8'b0010_0000,
        MODE_NUMBER    = 8'b0100_0000,
        MODE_STRING    = 8'b1000_0000
    } mode_t;

    typedef enum logic [2:0] {
        CLS_OPERATOR  = 3'd0,
        CLS_KEYWORD   = 3'd1,
        CLS_IDENT     = 3'd2,
        CLS_NUMBER    = 3'd3,
        CLS_STRING    = 3'd4,
        CLS_DIRECTIVE = 3'd5
    } token_class_t;

    typedef enum logic [0:0] {
        REQ_BYTE = 1'b0,
        REQ_END  = 1'b1
    } req_type_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_byte;
    } scan_req_t;

    typedef struct packed {
        logic [2:0]         token_class;
        logic [31:0]        token_start;
        logic [LenBits-1:0] token_length;
        logic               length_saturated;
        logic               last_result;
    } token_t;

    // Keywords left-justified, first character in the top byte.
    localparam logic [63:0] KwText [KwCount] = '{
        {"auto", 32'h0},     {"break", 24'h0},    {"case", 32'h0},    {"char", 32'h0},
        {"const", 24'h0},    "continue",          {"default", 8'h0},  {"do", 48'h0},
        {"double", 16'h0},   {"else", 32'h0},     {"enum", 32'h0},    {"extern", 16'h0},
        {"float", 24'h0},    {"for", 40'h0},      {"goto", 32'h0},    {"if", 48'h0},
        {"int", 40'h0},      {"long", 32'h0},     "register",         {"return", 16'h0},
        {"short", 24'h0},    {"signed", 16'h0},   {"sizeof", 16'h0},  {"static", 16'h0},
        {"struct", 16'h0},   {"switch", 16'h0},   {"typedef", 8'h0},  {"union", 24'h0},
        "unsigned",          {"void", 32'h0},     "volatile",         {"while", 24'h0}
    };

    localparam logic [3:0] KwLen [KwCount] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
        4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
        4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
    };

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    // Bytes beyond len are masked off, so unwritten buffer entries never matter.
    function automatic logic is_keyword(logic [63:0] text, logic [LenBits-1:0] len,
                                        logic over);
        logic        hit;
        logic [63:0] mask;
        hit  = 1'b0;
        mask = ~({64{1'b1}} >> {len[3:0], 3'b000});
        for (int i = 0; i < KwCount; i++) begin
            if (len[3:0] == KwLen[i] && ((text ^ KwText[i]) & mask) == 64'h0)
            begin
                hit = 1'b1;
            end
        end
        return hit && !over && (len <= LenBits'(KwChars));
    endfunction

endpackage

@@ rtl/core/c_token_scanner_unit.sv @@
// C token scanner top level: byte-serial lexer with a small result queue.
//
//  channel | direction | payload            | handshake
//  --------+-----------+--------------------+--------------------
//  in      | in        | scan_req_t in_data | in_valid / in_ready
//  out     | out       | token_t out_data   | out_valid / out_ready
//
// One request is taken per cycle; its state update and results are settled in
// the cycle of acceptance and results are written to a four-entry queue.
// Results leave one per cycle while out_ready is high; in_ready drops while
// fewer than two queue slots are free, as a byte can yield two results.
// Reset (rst_n low) clears scanner state and empties the queue; an
// end-of-input request flushes the pending token and restores the same state.
module c_token_scanner_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cts_pkg::scan_req_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cts_pkg::token_t   out_data
);
    import cts_pkg::*;

    mode_t              mode_reg, mode_next;
    logic               prev_star_reg, prev_star_next;
    logic               dot_seen_reg, dot_seen_next;
    logic               quote_dbl_reg, quote_dbl_next;
    logic [31:0]        start_reg, start_next;
    logic [LenBits-1:0] run_len_reg, run_len_next;
    logic               run_over_reg, run_over_next;
    logic [31:0]        offset_reg, offset_next;
    logic [7:0]         wbuf_reg [KwChars];
    logic [7:0]         wbuf_next [KwChars];

    token_t             q_reg [QDepth];
    logic [QPtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPtrW:0]     cnt_reg;

    logic               in_fire, out_fire;
    logic [7:0]         c;
    logic [63:0]        wtext;
    logic               kw_hit;
    logic [LenBits-1:0] grow_len;
    logic               grow_over;
    token_t             res0, res1;
    logic               res0_vld, res1_vld;
    logic               rescan, do_idle;
    token_t             op_res;

    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid & out_ready;
    assign in_ready  = (cnt_reg <= (QPtrW+1)'(QDepth - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_reg[rd_ptr_reg];
    assign c         = in_data.char_byte;

    always_comb
    begin
        for (int i = 0; i < KwChars; i++)
        begin
            wtext[63 - 8*i -: 8] = wbuf_reg[i];
        end
    end

    assign kw_hit    = is_keyword(wtext, run_len_reg, run_over_reg);
    assign grow_over = run_over_reg | (run_len_reg == LenMax);
    assign grow_len  = (run_len_reg == LenMax) ? run_len_reg : run_len_reg + 1'b1;

    always_comb
    begin
        op_res.token_class      = CLS_OPERATOR;
        op_res.token_start      = offset_reg;
        op_res.token_length     = LenBits'(1);
        op_res.length_saturated = 1'b0;
        op_res.last_result      = 1'b0;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        prev_star_next = prev_star_reg;
        dot_seen_next  = dot_seen_reg;
        quote_dbl_next = quote_dbl_reg;
        start_next     = start_reg;
        run_len_next   = run_len_reg;
        run_over_next  = run_over_reg;
        offset_next    = offset_reg;
        wbuf_next      = wbuf_reg;
        rescan         = 1'b0;
        do_idle        = 1'b0;
        res0_vld       = 1'b0;
        res1_vld       = 1'b0;
        res0.token_class      = CLS_OPERATOR;
        res0.token_start      = start_reg;
        res0.token_length     = run_len_reg;
        res0.length_saturated = run_over_reg;
        res0.last_result      = 1'b0;
        res1 = op_res;

        // Pending-token flush as seen from the current state
        case (mode_reg)
            MODE_SLASH:
            begin
                res0.token_length     = LenBits'(1);
                res0.length_saturated = 1'b0;
            end
            MODE_DIRECTIVE: res0.token_class = CLS_DIRECTIVE;
            MODE_WORD:      res0.token_class = kw_hit ? CLS_KEYWORD : CLS_IDENT;
            MODE_NUMBER:    res0.token_class = CLS_NUMBER;
            MODE_STRING:    res0.token_class = CLS_STRING;
            default:        res0.token_class = CLS_OPERATOR;
        endcase

        if (in_fire)
        begin
            if (in_data.req_type == REQ_END)
            begin
                res0_vld = (mode_reg == MODE_SLASH) || (mode_reg == MODE_DIRECTIVE) ||
                           (mode_reg == MODE_WORD) || (mode_reg == MODE_NUMBER) ||
                           (mode_reg == MODE_STRING);
                mode_next      = MODE_IDLE;
                prev_star_next = 1'b0;
                dot_seen_next  = 1'b0;
                quote_dbl_next = 1'b0;
                start_next     = '0;
                run_len_next   = '0;
                run_over_next  = 1'b0;
                offset_next    = '0;
            end
            else
            begin
                offset_next = offset_reg + 32'd1;
                case (mode_reg)
                    MODE_IDLE: do_idle = 1'b1;
                    MODE_SLASH:
                    begin
                        if (c == ChSlash)
                        begin
                            mode_next = MODE_LINE;
                        end
                        else if (c == ChStar)
                        begin
                            mode_next      = MODE_BLOCK;
                            prev_star_next = 1'b0;
                        end
                        else
                        begin
                            res0_vld = 1'b1;
                            rescan   = 1'b1;
                        end
                    end
                    MODE_LINE:
                    begin
                        if (c == ChNewline)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_BLOCK:
                    begin
                        if (prev_star_reg && c == ChSlash)
                        begin
                            mode_next      = MODE_IDLE;
                            prev_star_next = 1'b0;
                        end
                        else
                        begin
                            prev_star_next = (c == ChStar);
                        end
                    end
                    MODE_DIRECTIVE:
                    begin
                        if (is_alpha(c))
                        begin
                            run_len_next  = grow_len;
                            run_over_next = grow_over;
                        end
                        else
                        begin
                            res0_vld = 1'b1;
                            rescan   = 1'b1;
                        end
                    end
                    MODE_WORD:
                    begin
                        if (is_alpha(c) || is_digit(c) || c == ChUnder)
                        begin
                            if (!run_over_reg && run_len_reg < LenBits'(KwChars))
                            begin
                                wbuf_next[run_len_reg[KwIdxW-1:0]] = c;
                            end
                            run_len_next  = grow_len;
                            run_over_next = grow_over;
                        end
                        else
                        begin
                            res0_vld = 1'b1;
                            rescan   = 1'b1;
                        end
                    end
                    MODE_NUMBER:
                    begin
                        if (is_digit(c) || (c == ChDot && !dot_seen_reg))
                        begin
                            dot_seen_next = dot_seen_reg | (c == ChDot);
                            run_len_next  = grow_len;
                            run_over_next = grow_over;
                        end
                        else
                        begin
                            res0_vld = 1'b1;
                            rescan   = 1'b1;
                        end
                    end
                    MODE_STRING:
                    begin
                        run_len_next  = grow_len;
                        run_over_next = grow_over;
                        if (c == (quote_dbl_reg ? ChDquote : ChSquote))
                        begin
                            res0_vld              = 1'b1;
                            res0.token_length     = grow_len;
                            res0.length_saturated = grow_over;
                            mode_next             = MODE_IDLE;
                        end
                    end
                    default: mode_next = MODE_IDLE;
                endcase

                if (rescan)
                begin
                    mode_next = MODE_IDLE;
                end

                // Idle-mode scan: first pass, or the byte that ended a token
                if (do_idle || rescan)
                begin
                    if (!is_space(c))
                    begin
                        if (c == ChSlash || c == ChHash || is_alpha(c) || c == ChUnder ||
                            is_digit(c) || c == ChDquote || c == ChSquote)
                        begin
                            start_next    = offset_reg;
                            run_len_next  = LenBits'(1);
                            run_over_next = 1'b0;
                            if (c == ChSlash)
                            begin
                                mode_next = MODE_SLASH;
                            end
                            else if (c == ChHash)
                            begin
                                mode_next = MODE_DIRECTIVE;
                            end
                            else if (is_alpha(c) || c == ChUnder)
                            begin
                                mode_next    = MODE_WORD;
                                wbuf_next[0] = c;
                            end
                            else if (is_digit(c))
                            begin
                                mode_next     = MODE_NUMBER;
                                dot_seen_next = 1'b0;
                            end
                            else
                            begin
                                mode_next      = MODE_STRING;
                                quote_dbl_next = (c == ChDquote);
                            end
                        end
                        else if (do_idle)
                        begin
                            res0     = op_res;
                            res0_vld = 1'b1;
                        end
                        else
                        begin
                            res1_vld = 1'b1;
                        end
                    end
                end
            end
        end

        res0.last_result = ~res1_vld;
        res1.last_result = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            prev_star_reg <= 1'b0;
            dot_seen_reg  <= 1'b0;
            quote_dbl_reg <= 1'b0;
            start_reg     <= '0;
            run_len_reg   <= '0;
            run_over_reg  <= 1'b0;
            offset_reg    <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            prev_star_reg <= prev_star_next;
            dot_seen_reg  <= dot_seen_next;
            quote_dbl_reg <= quote_dbl_next;
            start_reg     <= start_next;
            run_len_reg   <= run_len_next;
            run_over_reg  <= run_over_next;
            offset_reg    <= offset_next;
            wr_ptr_reg    <= wr_ptr_reg + QPtrW'(res0_vld) + QPtrW'(res1_vld);
            rd_ptr_reg    <= rd_ptr_reg + QPtrW'(out_fire);
            cnt_reg       <= cnt_reg + (QPtrW+1)'(res0_vld) + (QPtrW+1)'(res1_vld)
                             - (QPtrW+1)'(out_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        wbuf_reg <= wbuf_next;
        if (res0_vld)
        begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (res1_vld)
        begin
            q_reg[wr_ptr_reg + QPtrW'(1)] <= res1;
        end
    end

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QPtrW+1)'(QDepth))
        else $error("result queue overflow");

    // end of input returns the scanner to its reset position
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.req_type == REQ_END |=>
            mode_reg == MODE_IDLE && offset_reg == 32'd0 && run_len_reg == '0)
        else $error("end of input did not restore scanner state");

    // each source byte advances the offset by one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.req_type == REQ_BYTE |=> offset_reg == $past(offset_reg) + 32'd1)
        else $error("byte offset did not advance");

    // overflow is only flagged once the length counter has saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        run_over_reg |-> run_len_reg == LenMax)
        else $error("length overflow without saturated count");

endmodule
